/* sv/ccp_pkg.sv */
`default_nettype none

package ccp_pkg;

  // Frame table geometry.
  localparam int FRAMES  = 1024;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int COUNT_W = FRAME_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(FRAMES);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] RUN_MAX     = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_EVICT   = 2'd0,
    CMD_INSTALL = 2'd1,
    CMD_ACCESS  = 2'd2,
    CMD_PIN     = 2'd3
  } cmd_t;

  // Per-frame flags as held in the flag memory.
  typedef struct packed {
    logic has_slot;
    logic read_only;
    logic in_image;
    logic dirty;
    logic pinned;
    logic used;
  } flags_t;

  typedef struct packed {
    cmd_t        command;
    logic [9:0]  frame;
    logic        is_write;
    logic        pinned;
    logic        read_only;
    logic        in_image;
    logic        has_slot;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  victim_frame;
    logic        write_back;
    logic        need_slot;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DELIVER
  } state_t;

endpackage

`default_nettype wire

/* sv/ccp_flag_ram.sv */
`default_nettype none

module ccp_flag_ram (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [ccp_pkg::FRAME_W-1:0]  waddr,
  input  ccp_pkg::flags_t              wdata,
  input  wire  [ccp_pkg::FRAME_W-1:0]  raddr,
  output ccp_pkg::flags_t              rdata
);
  import ccp_pkg::*;

  flags_t mem [FRAMES];

  // Write-first: a read of the entry being written returns the new flags.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/clock_page_replacement_core.sv */
`default_nettype none
// Install, access and pin pass through the update state; an eviction passes through the
// scan state, where the hand visits one frame per cycle (at most about twice the clamped
// frame count), and then the delivery state. One transfer is handled at a time; the flag
// memory read-modify-write loop sets the pace of the scan. After reset the flag memory is
// swept clear before the first request transfer is taken; configuration writes are taken throughout.

module clock_page_replacement_core (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  ccp_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  wire                            rsp_ready,
  output ccp_pkg::rsp_t                  rsp,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ccp_pkg::COUNT_W-1:0]    cfg_data
);
  import ccp_pkg::*;

  // Control and datapath registers.
  state_t               state;
  state_t               state_next;
  logic [FRAME_W-1:0]   clr_addr;
  logic [COUNT_W-1:0]   frame_count;
  logic [FRAME_W-1:0]   hand;
  logic [COUNT_W-1:0]   pinned_run;
  logic [FRAME_W-1:0]   cur;
  req_t                 req_q;
  rsp_t                 res;

  // Flag memory port.
  logic                 ram_we;
  logic [FRAME_W-1:0]   ram_waddr;
  flags_t               ram_wdata;
  logic [FRAME_W-1:0]   ram_raddr;
  flags_t               ram_rdata;

  // Scan step signals.
  logic [COUNT_W-1:0]   cap;
  logic [FRAME_W-1:0]   start;
  logic [FRAME_W-1:0]   nxt;
  logic [COUNT_W-1:0]   run_new;
  logic                 hit;
  logic                 fail;
  logic                 wb;
  logic                 ns;
  logic                 frame_ok;
  flags_t               upd_flags;
  logic                 req_xfer;

  assign req_xfer  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  ccp_flag_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The configured frame count is clamped to the range the table supports. The hand
  // restarts at frame one when it is unset or no longer below the count.
  always_comb begin
    if (frame_count < COUNT_MIN) begin
      cap = COUNT_MIN;
    end else if (frame_count > COUNT_MAX) begin
      cap = COUNT_MAX;
    end else begin
      cap = frame_count;
    end
    if ((hand == '0) || ({1'b0, hand} >= cap)) begin
      start = FRAME_W'(1);
    end else begin
      start = hand;
    end
  end

  // One step of the clock: the flags of the frame under the hand arrive from memory in the
  // cycle after their read was issued. Pinned frames lengthen the pinned run, any other
  // frame ends it; a used frame gets its second chance, an unused one is the victim.
  always_comb begin
    if (({1'b0, cur} + COUNT_W'(1)) >= cap) begin
      nxt = FRAME_W'(1);
    end else begin
      nxt = cur + FRAME_W'(1);
    end
    if (ram_rdata.pinned) begin
      run_new = (pinned_run == RUN_MAX) ? pinned_run : pinned_run + COUNT_W'(1);
    end else begin
      run_new = '0;
    end
    hit  = !ram_rdata.pinned && !ram_rdata.used;
    fail = !hit && (run_new >= cap);
    // Pages from the program image are never written back; a page that already owns a
    // slot is written back only when it is dirty and writable.
    wb = !ram_rdata.in_image &&
         !((ram_rdata.read_only || !ram_rdata.dirty) && ram_rdata.has_slot);
    ns = wb && !ram_rdata.has_slot;
  end

  // New flags for install, access and pin commands.
  always_comb begin
    frame_ok  = (32'(req_q.frame) < FRAMES);
    upd_flags = ram_rdata;
    case (req_q.command)
      CMD_INSTALL: begin
        upd_flags           = '0;
        upd_flags.used      = 1'b1;
        upd_flags.pinned    = req_q.pinned;
        upd_flags.read_only = req_q.read_only;
        upd_flags.in_image  = req_q.in_image;
        upd_flags.has_slot  = req_q.has_slot;
      end
      CMD_ACCESS: begin
        upd_flags.used = 1'b1;
        if (req_q.is_write) begin
          upd_flags.dirty = 1'b1;
        end
      end
      CMD_PIN: begin
        upd_flags.pinned = req_q.pinned;
      end
      default: begin
        upd_flags = ram_rdata;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == FRAME_W'(FRAMES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = (req.command == CMD_EVICT) ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit || fail) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory control and request handshake. While the scan is running the read of the next
  // frame is issued in the same cycle as the write-back of the current one; the memory's
  // write-first read covers the case where both are the same frame.
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = '0;
    ram_raddr = cur;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        ram_raddr = (req.command == CMD_EVICT) ? start : req.frame;
      end
      ST_UPDATE: begin
        ram_we    = frame_ok;
        ram_waddr = req_q.frame;
        ram_wdata = upd_flags;
      end
      ST_SCAN: begin
        ram_raddr = nxt;
        if (hit) begin
          ram_we = 1'b1;
        end else if (!ram_rdata.pinned) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata;
          ram_wdata.used = 1'b0;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      frame_count <= COUNT_RESET;
      hand        <= '0;
      pinned_run  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + FRAME_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        frame_count <= cfg_data;
      end
      if (state == ST_SCAN) begin
        pinned_run <= run_new;
        if (hit) begin
          hand <= nxt;
        end else if (fail) begin
          // The hand rests on the pinned frame where the scan gave up.
          hand <= cur;
        end
      end
      if ((state == ST_DELIVER) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q <= req;
      cur   <= start;
    end
    if (state == ST_SCAN) begin
      if (hit) begin
        res.found        <= 1'b1;
        res.victim_frame <= cur;
        res.write_back   <= wb;
        res.need_slot    <= ns;
      end else if (fail) begin
        res <= '0;
      end else begin
        cur <= nxt;
      end
    end
    if ((state == ST_DELIVER) && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

  // A result is raised only on leaving the delivery state.
  a_rsp_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DELIVER))
    else $error("response raised outside delivery");

  // A failed eviction reports nothing else.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |->
      (rsp.victim_frame == '0) && !rsp.write_back && !rsp.need_slot)
    else $error("failed eviction carries data");

  // Frame zero is never chosen as a victim.
  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (rsp.victim_frame != '0))
    else $error("frame zero evicted");

  // The hand under scan always lies within the scanned frames.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((cur != '0) && ({1'b0, cur} < cap)))
    else $error("scan outside frame range");

  // A write-back needing a slot only occurs for a victim.
  a_slot_needs_wb: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.need_slot) |-> (rsp.found && rsp.write_back))
    else $error("slot request without write-back");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

// Testbench for the clock page replacement core.
// A short table of directed steps comes first. Then come nine random phases, each run under its
// own frame count setting. A predictor mirrors the frame flag table, the clock hand and the
// pinned run counter. It queues the victim that each eviction should give. Every result
// transfer is checked field by field against the oldest queued victim.

module tb_top;
  import ccp_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  // Install, access and pin give no result, so the core may still be busy with one
  // of them when the last victim arrives; this many cycles covers that tail.
  localparam int SETTLE_CYCLES = 8;

  // One row of the directed table: either a frame count write or a request. A request
  // may carry a hand-written result, which then replaces the predicted one.
  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] cfg;
    req_t               rq;
    bit                 typed;
    rsp_t               want;
  } step_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  // Predictor state: a private copy of what the core keeps.
  flags_t             flag_tbl [FRAMES];
  logic [FRAME_W-1:0] hand_pos;
  logic [COUNT_W-1:0] pin_streak;
  logic [COUNT_W-1:0] count_setting;

  rsp_t  pending_victims [$];
  step_t plan [$];

  int send_idle_pct = 9;
  int recv_idle_pct = 63;
  bit hold_ask      = 1'b0;
  int hold_left     = 0;
  int cycles        = 0;
  int faults        = 0;
  int requests_sent = 0;
  int evictions_done   = 0;
  int evictions_failed = 0;

  int phase_count [9] = '{5, 2, 17, 1024, 0, 64, 2047, 9, 1};
  int phase_items [9] = '{50, 25, 45, 25, 20, 45, 20, 40, 20};

  clock_page_replacement_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Hard stop, in case a handshake never completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d victims outstanding", cycles,
               pending_victims.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    faults++;
  endtask

  // The register is clamped into the range 2 to FRAMES before use.
  function automatic int eff_count();
    int c;
    c = int'(count_setting);
    if (c < int'(COUNT_MIN)) c = int'(COUNT_MIN);
    if (c > int'(COUNT_MAX)) c = int'(COUNT_MAX);
    return c;
  endfunction

  // Walks the hand just as the core should. Pinned frames lengthen the run, and any
  // unpinned frame ends it. A used frame loses its used bit and is passed over. The
  // first frame that is neither used nor pinned is the victim.
  function automatic rsp_t pick_victim();
    int     cap;
    int     h;
    flags_t f;
    rsp_t   o;
    logic   wb;
    cap = eff_count();
    h   = int'(hand_pos);
    o   = '0;
    if (h == 0 || h >= cap) h = 1;
    while (1) begin
      f = flag_tbl[h];
      if (f.pinned) begin
        if (pin_streak < RUN_MAX) pin_streak = pin_streak + 1'b1;
      end else begin
        pin_streak = '0;
        if (f.used) begin
          f.used = 1'b0;
          flag_tbl[h] = f;
        end else begin
          break;
        end
      end
      // Give up with the hand parked on the pinned frame; the run is kept.
      if (int'(pin_streak) >= cap) begin
        hand_pos = FRAME_W'(h);
        return o;
      end
      h++;
      if (h >= cap) h = 1;
    end
    // Image pages are never written back. Nor is a page with a slot that is clean or
    // read-only.
    if (f.in_image) wb = 1'b0;
    else if ((f.read_only || !f.dirty) && f.has_slot) wb = 1'b0;
    else wb = 1'b1;
    o.found        = 1'b1;
    o.victim_frame = FRAME_W'(h);
    o.write_back   = wb;
    o.need_slot    = wb && !f.has_slot;
    flag_tbl[h] = '0;
    hand_pos = (h + 1 >= cap) ? FRAME_W'(1) : FRAME_W'(h + 1);
    return o;
  endfunction

  function automatic void apply_frame_cmd(input req_t r);
    flags_t f;
    f = flag_tbl[r.frame];
    case (r.command)
      CMD_INSTALL: begin
        f           = '0;
        f.used      = 1'b1;
        f.pinned    = r.pinned;
        f.read_only = r.read_only;
        f.in_image  = r.in_image;
        f.has_slot  = r.has_slot;
      end
      CMD_ACCESS: begin
        // A write sets dirty even when the page is read-only.
        f.used = 1'b1;
        if (r.is_write) f.dirty = 1'b1;
      end
      CMD_PIN: begin
        f.pinned = r.pinned;
      end
      default: ;
    endcase
    flag_tbl[r.frame] = f;
  endfunction

  function automatic step_t row_cfg(input int v);
    step_t s;
    s        = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg    = COUNT_W'(v);
    return s;
  endfunction

  function automatic step_t row_req(input cmd_t c, input int fr, input bit wr, input bit pn,
                                    input bit ro, input bit img, input bit sl);
    step_t s;
    s              = '{default: '0};
    s.rq.command   = c;
    s.rq.frame     = FRAME_W'(fr);
    s.rq.is_write  = wr;
    s.rq.pinned    = pn;
    s.rq.read_only = ro;
    s.rq.in_image  = img;
    s.rq.has_slot  = sl;
    return s;
  endfunction

  // An eviction whose result is written out by hand.
  function automatic step_t row_typed(input bit fnd, input int vf, input bit wb, input bit ns);
    step_t s;
    s                   = '{default: '0};
    s.rq.command        = CMD_EVICT;
    s.typed             = 1'b1;
    s.want.found        = fnd;
    s.want.victim_frame = FRAME_W'(vf);
    s.want.write_back   = wb;
    s.want.need_slot    = ns;
    return s;
  endfunction

  // Random request. Most frames fall within the scanned range so that evictions meet
  // real flags. Some frames are zero or anywhere in the table, which the scan must skip.
  function automatic req_t random_request(input int cap);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.command = CMD_EVICT;
    else if (pick < 65) r.command = CMD_INSTALL;
    else if (pick < 88) r.command = CMD_ACCESS;
    else r.command = CMD_PIN;
    pick = $urandom_range(0, 9);
    if (pick == 0) r.frame = FRAME_W'($urandom_range(0, FRAMES - 1));
    else if (pick == 1) r.frame = '0;
    else r.frame = FRAME_W'($urandom_range(1, cap - 1));
    r.is_write  = $urandom_range(0, 1);
    r.pinned    = ($urandom_range(0, 3) == 0);
    r.read_only = $urandom_range(0, 1);
    r.in_image  = ($urandom_range(0, 3) == 0);
    r.has_slot  = $urandom_range(0, 1);
    return r;
  endfunction

  // Offers one request and returns at the edge where the transfer happens. Valid is
  // left high after the transfer. The next call either keeps it high or drops it for
  // an idle gap. That way valid never gets two assignments in one time step.
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t o;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
    if (r.command == CMD_EVICT) begin
      o = pick_victim();
      pending_victims.push_back(typed ? want : o);
    end else begin
      apply_frame_cmd(r);
    end
  endtask

  // Stops offering and waits until every victim has arrived and the core has gone quiet.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    count_setting = v;
  endtask

  // Receiver: checks each result transfer, then decides on ready for the next cycle.
  // A long hold-off, when asked for, is counted out here. Meanwhile the sender keeps
  // offering requests, so the core fills up and stalls its input.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_victims.size() == 0) begin
          report_mismatch($sformatf("result transfer with no eviction pending, frame %0d",
                                    rsp.victim_frame));
        end else begin
          want = pending_victims.pop_front();
          evictions_done++;
          if (!want.found) evictions_failed++;
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found got %0d expected %0d", rsp.found, want.found));
          if (rsp.victim_frame !== want.victim_frame)
            report_mismatch($sformatf("victim_frame got %0d expected %0d",
                                      rsp.victim_frame, want.victim_frame));
          if (rsp.write_back !== want.write_back)
            report_mismatch($sformatf("write_back got %0d expected %0d (victim %0d)",
                                      rsp.write_back, want.write_back, want.victim_frame));
          if (rsp.need_slot !== want.need_slot)
            report_mismatch($sformatf("need_slot got %0d expected %0d (victim %0d)",
                                      rsp.need_slot, want.need_slot, want.victim_frame));
        end
      end
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int p;
    int k;
    for (k = 0; k < FRAMES; k++) flag_tbl[k] = '0;
    hand_pos      = '0;
    pin_streak    = '0;
    count_setting = COUNT_RESET;

    // Directed steps. Hand-written results cover the plain cases: an empty table after
    // reset, the smallest count, and failure with every scanned frame pinned.
    plan.push_back(row_typed(1, 1, 1, 1));
    plan.push_back(row_cfg(0));
    // The hand sits past the end of the scanned range, so the scan restarts at frame one.
    plan.push_back(row_typed(1, 1, 1, 1));
    plan.push_back(row_req(CMD_INSTALL, 1, 0, 1, 0, 0, 0));
    plan.push_back(row_typed(0, 0, 0, 0));
    // The run counter keeps its value, so the next attempt fails at once.
    plan.push_back(row_typed(0, 0, 0, 0));
    plan.push_back(row_req(CMD_PIN, 1, 0, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_cfg(2047));
    plan.push_back(row_req(CMD_INSTALL, 1023, 0, 0, 1, 1, 1));
    plan.push_back(row_req(CMD_ACCESS, 1023, 1, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_ACCESS, 0, 1, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_INSTALL, 1, 0, 0, 0, 0, 1));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_cfg(3));
    plan.push_back(row_req(CMD_INSTALL, 2, 0, 0, 1, 0, 1));
    plan.push_back(row_req(CMD_ACCESS, 2, 1, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_INSTALL, 1, 0, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_cfg(1025));
    plan.push_back(row_req(CMD_ACCESS, 1, 1, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_req(CMD_INSTALL, 1, 0, 1, 1, 1, 1));
    plan.push_back(row_req(CMD_EVICT, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_frame_count(plan[i].cfg);
      end else begin
        send_req(plan[i].rq, plan[i].typed, plan[i].want);
      end
    end

    // Random phases. The first three run with a slow receiver, the next three with a slow
    // sender, and the last three with no idling at all apart from one long hold-off.
    for (p = 0; p < 9; p++) begin
      drain();
      write_frame_count(COUNT_W'(phase_count[p]));
      if (p == 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 9;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask      = 1'b1;
      end
      for (k = 0; k < phase_items[p]; k++)
        send_req(random_request(eff_count()), 1'b0, '0);
    end
    drain();

    $display("Sent %0d requests; %0d evictions checked, %0d of them with every frame pinned.",
             requests_sent, evictions_done, evictions_failed);
    $display("Frame counts from 0 to 2047 were set, with both slow and stalled handshakes.");
    if (faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", faults);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
